// ===== rtl/ebsc_pkg.sv =====
// Package with register indexes, escape codes and the per-byte coding function of the codec.
package ebsc_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_BYTE = 2'd2;

	localparam logic [7:0] SYNC_RESET   = 8'hAA;
	localparam logic [7:0] ESCAPE_RESET = 8'hA9;

	// Second byte of an escape pair.
	localparam logic [7:0] CODE_SYNC   = 8'h01;
	localparam logic [7:0] CODE_ESCAPE = 8'h00;

	typedef struct packed {
		logic [1:0] count;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       pending;
	} code_res_t;

	// Results of one byte and the escape flag it leaves behind.
	function automatic code_res_t ebsc_code(
		input logic       decode_mode,
		input logic [7:0] sync_byte,
		input logic [7:0] escape_byte,
		input logic       pending,
		input logic [7:0] data_byte,
		input logic       frame_end
	);
		code_res_t r;
		r.count   = 2'd1;
		r.byte0   = data_byte;
		r.byte1   = CODE_ESCAPE;
		r.pending = 1'b0;
		if (!decode_mode) begin
			if (data_byte == sync_byte) begin
				r.count = 2'd2;
				r.byte0 = escape_byte;
				r.byte1 = CODE_SYNC;
			end else if (data_byte == escape_byte) begin
				r.count = 2'd2;
				r.byte0 = escape_byte;
				r.byte1 = CODE_ESCAPE;
			end
		end else begin
			if (data_byte == escape_byte) begin
				r.count   = 2'd0;
				r.pending = 1'b1;
			end else if (pending) begin
				r.byte0 = (data_byte == CODE_SYNC) ? sync_byte : escape_byte;
			end
		end
		if (frame_end) begin
			r.pending = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/ebus_byte_stuffing_codec.sv =====
// Top level of the streaming byte-stuffing codec: input stage, coding logic and output register.
//
// Channel   Handshake              Payload
// input     in_valid / in_ready    data_byte, frame_end
// output    out_valid / out_ready  out_byte, run_last, frame_done
// config    cfg_we                 cfg_index, cfg_data
//
// An escaped byte in encode mode stays in the input stage for both bytes of its pair, since the
// output register moves one byte per cycle while out_ready allows; any other request leaves
// with its single byte or none. A request passes the input stage, then the output register.
// Reset clears the stages, the escape flag and loads the default register values. A stalled
// output holds its byte and the input stage keeps the request until its last byte is registered.
module ebus_byte_stuffing_codec
	import ebsc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   frame_end,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_byte,
	output logic                   run_last,
	output logic                   frame_done
);

	logic       decode_mode_q;
	logic [7:0] sync_byte_q;
	logic [7:0] escape_byte_q;
	logic       pending_q;

	logic       valid_s1;
	logic       phase_s1;
	logic [7:0] data_s1;
	logic       fend_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       frame_done_q;

	code_res_t  res;
	logic       out_load;
	logic       emit;
	logic       last_byte;
	logic       done_s1;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			sync_byte_q   <= SYNC_RESET;
			escape_byte_q <= ESCAPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECODE_MODE: decode_mode_q <= cfg_data[0];
				REG_SYNC_BYTE:   sync_byte_q   <= cfg_data;
				REG_ESCAPE_BYTE: escape_byte_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		res = ebsc_code(decode_mode_q, sync_byte_q, escape_byte_q, pending_q, data_s1, fend_s1);
	end

	assign out_load  = !out_valid_q || out_ready;
	assign last_byte = phase_s1 || (res.count == 2'd1);
	assign emit      = valid_s1 && (res.count != 2'd0) && out_load;
	// A request with no result leaves at once; others leave with their last byte.
	assign done_s1   = valid_s1 && ((res.count == 2'd0) || (out_load && last_byte));
	assign in_ready  = !valid_s1 || done_s1;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			phase_s1  <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			if (done_s1) begin
				phase_s1  <= 1'b0;
				pending_q <= res.pending;
			end else if (emit) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			fend_s1 <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= phase_s1 ? res.byte1 : res.byte0;
			run_last_q   <= last_byte;
			frame_done_q <= fend_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

	// The second byte of a pair only exists while a request sits in the input stage.
	assert property (@(posedge clk) disable iff (!arst_n) phase_s1 |-> valid_s1)
		else $error("second phase without a request in the input stage");

	// Decode mode never produces a byte pair.
	assert property (@(posedge clk) disable iff (!arst_n) phase_s1 |-> !decode_mode_q)
		else $error("byte pair in decode mode");

	// An accepted request always occupies the input stage in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> valid_s1)
		else $error("accepted request lost");

	// Encode mode leaves no escape pending once a request has left.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_s1 && !decode_mode_q) |=> !pending_q)
		else $error("escape pending after encode");

endmodule

// ===== sim/tb_ebus_byte_stuffing_codec.sv =====
// Self-checking testbench of the byte-stuffing codec: directed cases, then random frames.
module tb_ebus_byte_stuffing_codec;
	import ebsc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_GAP      = 13;
	localparam int RANDOM_BYTES = 1550;
	localparam int PHASES       = 10;
	localparam int SETTLE_WAIT  = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {IDLE_BOTH, IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER} idle_mode_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       done;
	} coded_byte_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [7:0]             data_byte = '0;
	logic                   frame_end = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [7:0]             out_byte;
	logic                   run_last;
	logic                   frame_done;

	// Local copy of the codec registers and its escape flag.
	logic       model_decode = 1'b0;
	logic [7:0] model_sync   = SYNC_RESET;
	logic [7:0] model_escape = ESCAPE_RESET;
	logic       escape_held  = 1'b0;

	coded_byte_t coded_bytes_due[$];
	idle_mode_t  idle_mode   = IDLE_BOTH;
	int          errors      = 0;
	int          bytes_sent  = 0;
	int          cycle_count = 0;

	always #1 clk = ~clk;

	ebus_byte_stuffing_codec i_dut (.*);

	function automatic int draw_gap(input logic side_idles);
		return side_idles ? $urandom_range(0, MAX_GAP) : 0;
	endfunction

	function automatic void apply_stuffing(input logic [7:0] b, input logic fe);
		if (!model_decode) begin
			if (b == model_sync) begin
				coded_bytes_due.push_back(coded_byte_t'{value: model_escape, last: 1'b0, done: fe});
				coded_bytes_due.push_back(coded_byte_t'{value: CODE_SYNC, last: 1'b1, done: fe});
			end else if (b == model_escape) begin
				coded_bytes_due.push_back(coded_byte_t'{value: model_escape, last: 1'b0, done: fe});
				coded_bytes_due.push_back(coded_byte_t'{value: CODE_ESCAPE, last: 1'b1, done: fe});
			end else begin
				coded_bytes_due.push_back(coded_byte_t'{value: b, last: 1'b1, done: fe});
			end
			escape_held = 1'b0;
		end else if (b == model_escape) begin
			escape_held = 1'b1;
		end else if (escape_held) begin
			coded_bytes_due.push_back(coded_byte_t'{
				value: (b == CODE_SYNC) ? model_sync : model_escape, last: 1'b1, done: fe});
			escape_held = 1'b0;
		end else begin
			coded_bytes_due.push_back(coded_byte_t'{value: b, last: 1'b1, done: fe});
		end
		if (fe) begin
			escape_held = 1'b0;
		end
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1: return model_escape;
			2: return model_sync;
			3: return CODE_SYNC;
			4: return CODE_ESCAPE;
			default: return 8'($urandom);
		endcase
	endfunction

	// Called at a rising edge; returns at the edge that accepts the request.
	task automatic send_byte(input logic [7:0] b, input logic fe);
		int gap;
		gap = draw_gap(idle_mode == IDLE_BOTH || idle_mode == IDLE_SENDER);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		frame_end <= fe;
		do @(posedge clk); while (!(in_valid && in_ready));
		apply_stuffing(b, fe);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_DECODE_MODE: model_decode = val[0];
			REG_SYNC_BYTE:   model_sync   = val;
			REG_ESCAPE_BYTE: model_escape = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A swallowed escape gives no result, so allow the pipeline time beyond the last result.
	task automatic settle();
		in_valid <= 1'b0;
		while (coded_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic set_codes(input logic [7:0] sync_val, input logic [7:0] esc_val);
		write_reg(REG_SYNC_BYTE, sync_val);
		write_reg(REG_ESCAPE_BYTE, esc_val);
	endtask

	task automatic test_encode();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(SYNC_RESET, 1'b0);
		send_byte(ESCAPE_RESET, 1'b0);
		send_byte(CODE_SYNC, 1'b0);
		send_byte(8'h5A, 1'b1);
		settle();
	endtask

	task automatic test_decode();
		write_reg(REG_DECODE_MODE, 8'h01);
		send_byte(8'h55, 1'b0);
		send_byte(ESCAPE_RESET, 1'b0);
		send_byte(CODE_SYNC, 1'b0);
		// Of two escapes in a row only the second one counts.
		send_byte(ESCAPE_RESET, 1'b0);
		send_byte(ESCAPE_RESET, 1'b0);
		send_byte(CODE_SYNC, 1'b0);
		send_byte(ESCAPE_RESET, 1'b0);
		send_byte(8'h7E, 1'b0);
		// An escape that ends its frame is dropped, so the next byte passes through.
		send_byte(ESCAPE_RESET, 1'b1);
		send_byte(CODE_SYNC, 1'b0);
		send_byte(ESCAPE_RESET, 1'b0);
		send_byte(CODE_ESCAPE, 1'b1);
		settle();
	endtask

	task automatic test_mode_switch();
		send_byte(ESCAPE_RESET, 1'b0);
		settle();
		write_reg(REG_DECODE_MODE, 8'h00);
		send_byte(CODE_SYNC, 1'b0);
		settle();
		write_reg(REG_DECODE_MODE, 8'hFF);
		send_byte(CODE_SYNC, 1'b1);
		settle();
	endtask

	task automatic test_equal_codes();
		set_codes(8'h3C, 8'h3C);
		write_reg(REG_UNUSED, 8'h5D);
		write_reg(REG_DECODE_MODE, 8'h00);
		send_byte(8'h3C, 1'b0);
		settle();
		write_reg(REG_DECODE_MODE, 8'h01);
		send_byte(8'h3C, 1'b0);
		send_byte(CODE_SYNC, 1'b0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h05, 1'b1);
		settle();
	endtask

	task automatic test_random();
		int   target;
		int   len;
		int   k;
		logic [7:0] code;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_codes(8'h00, 8'hFF);
				1: set_codes(8'hFF, 8'h00);
				2, 3: begin
					code = 8'($urandom);
					set_codes(code, code);
				end
				8, 9: set_codes(SYNC_RESET, ESCAPE_RESET);
				default: set_codes(8'($urandom), 8'($urandom));
			endcase
			write_reg(REG_DECODE_MODE, {7'($urandom), 1'(phase % 2)});
			write_reg(REG_UNUSED, 8'($urandom));
			idle_mode = idle_mode_t'($urandom_range(0, 3));
			target = bytes_sent + RANDOM_BYTES / PHASES;
			while (bytes_sent < target) begin
				len = $urandom_range(1, 12);
				k = 0;
				while (k < len) begin
					if (model_decode && k < len - 1 && $urandom_range(0, 2) == 0) begin
						// A well-formed escape pair, with now and then a bad code after it.
						send_byte(model_escape, 1'b0);
						k++;
						if ($urandom_range(0, 3) == 0) begin
							code = 8'($urandom);
						end else begin
							code = $urandom_range(0, 1) ? CODE_SYNC : CODE_ESCAPE;
						end
						send_byte(code, k == len - 1);
					end else begin
						send_byte(pick_byte(), k == len - 1);
					end
					k++;
				end
			end
			settle();
		end
	endtask

	always @(posedge clk) begin : check_results
		coded_byte_t due;
		if (arst_n && out_valid && out_ready) begin
			if (coded_bytes_due.size() == 0) begin
				$display("%0t: result with none expected: out_byte %02h run_last %0b frame_done %0b",
					$time, out_byte, run_last, frame_done);
				errors++;
			end else begin
				due = coded_bytes_due.pop_front();
				if (out_byte !== due.value) begin
					$display("%0t: out_byte expected %02h, actual %02h", $time, due.value, out_byte);
					errors++;
				end
				if (run_last !== due.last) begin
					$display("%0t: run_last expected %0b, actual %0b", $time, due.last, run_last);
					errors++;
				end
				if (frame_done !== due.done) begin
					$display("%0t: frame_done expected %0b, actual %0b", $time, due.done, frame_done);
					errors++;
				end
			end
		end
	end

	initial begin : accept_results
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap(idle_mode == IDLE_BOTH || idle_mode == IDLE_RECEIVER);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode();
		test_decode();
		test_mode_switch();
		test_equal_codes();
		test_random();
		settle();
		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
